@@ rtl/tseq_pkg.sv @@
`timescale 1ns / 1ps
package tseq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W       = 7;
	localparam int TIME_W      = 32;
	localparam int KIND_W      = 2;
	localparam int DATA_W      = 32;
	localparam int S_DATA_W    = 72;
	localparam int M_DATA_W    = 80;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_POPPED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] due_time;
		logic [KIND_W-1:0] event_kind;
		logic [DATA_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctrl_t;

	typedef struct packed {
		status_t          status;
		entry_t           entry;
		logic [OCC_W-1:0] occupancy;
	} result_t;

endpackage

@@ rtl/timestamp_sorted_event_queue_core.sv @@
`timescale 1ns / 1ps
// The result of an accepted item is registered in the output stage before it is on m_tvalid.
// Throughput: one item per cycle while s_tready is high; each chain cell compares and shifts
// in the accept cycle, and a two-entry output stage keeps input flowing while one result waits.
// Reset (arst_n low): event count and output valids cleared; cell contents are not
// reset and are only read below the count.
module timestamp_sorted_event_queue_core
	import tseq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // due_time[31:0], event_kind[33:32], payload[65:34]
	input  logic                s_tuser,  // cmd[0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // out_time[31:0], out_kind[33:32],
	                                      // out_payload[65:34], occupancy[72:66]
	output logic [1:0]          m_tuser   // status[1:0]
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             accept;
	logic             full;
	logic             empty;
	cmd_t             cmd;
	entry_t           new_entry;
	cell_ctrl_t       ctrl;
	result_t          res;
	result_t          out_res;

	logic   [QUEUE_DEPTH-1:0] occ;
	logic   [QUEUE_DEPTH-1:0] keep;
	entry_t                   cell_entry [QUEUE_DEPTH];

	assign cmd       = cmd_t'(s_tuser);
	assign new_entry = '{due_time: s_tdata[31:0], event_kind: s_tdata[33:32],
		payload: s_tdata[65:34]};

	assign accept = s_tvalid && s_tready;
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);

	assign ctrl.insert = accept && (cmd == CMD_INSERT) && !full;
	assign ctrl.pop    = accept && (cmd == CMD_REMOVE) && !empty;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic   prev_keep;
			entry_t prev_entry;
			entry_t next_entry;

			assign occ[gi] = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_head
				assign prev_keep  = 1'b1;
				assign prev_entry = new_entry;
			end else begin : g_mid
				assign prev_keep  = keep[gi-1];
				assign prev_entry = cell_entry[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				assign next_entry = cell_entry[gi];
			end else begin : g_body
				assign next_entry = cell_entry[gi+1];
			end

			tseq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occ        (occ[gi]),
				.prev_keep  (prev_keep),
				.new_entry  (new_entry),
				.prev_entry (prev_entry),
				.next_entry (next_entry),
				.keep       (keep[gi]),
				.entry      (cell_entry[gi])
			);
		end
	endgenerate

	always_comb begin
		count_nxt = count_q;
		if (ctrl.insert) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_comb begin
		res.entry     = '0;
		res.occupancy = OCC_W'(count_nxt);
		unique case (cmd)
			CMD_INSERT: res.status = full ? ST_FULL : ST_INSERTED;
			CMD_REMOVE: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					res.status = ST_POPPED;
					res.entry  = cell_entry[0];
				end
			end
			default: res.status = ST_EMPTY;
		endcase
	end

	tseq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_res    (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tuser = out_res.status;
	assign m_tdata = {7'd0, out_res.occupancy, out_res.entry.payload,
		out_res.entry.event_kind, out_res.entry.due_time};

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("event count above depth");
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_INSERT) && full |=> $stable(count_q))
		else $error("dropped insert changed the count");
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_REMOVE) && empty |=> count_q == '0)
		else $error("empty pop changed the count");
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		occ[1] |-> cell_entry[0].due_time <= cell_entry[1].due_time)
		else $error("head cells out of order");
`endif

endmodule

@@ rtl/tseq_cell.sv @@
`timescale 1ns / 1ps
module tseq_cell
	import tseq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  logic       prev_keep,
	input  entry_t     new_entry,
	input  entry_t     prev_entry,
	input  entry_t     next_entry,
	output logic       keep,
	output entry_t     entry
);

	entry_t entry_q;

	// an occupied cell stays put on insert if its time is equal or earlier
	assign keep  = occ && (entry_q.due_time <= new_entry.due_time);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!keep) begin
				if (prev_keep) begin
					entry_q <= new_entry;
				end else begin
					entry_q <= prev_entry;
				end
			end
		end else if (ctrl.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule

@@ rtl/tseq_obuf.sv @@
`timescale 1ns / 1ps
module tseq_obuf
	import tseq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  result_t in_res,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    take;
	logic    put;

	assign in_ready  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign take      = out_v_q && out_ready;
	assign put       = in_valid && !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (take) begin
					skid_v_q <= 1'b0;
				end
			end else if (put) begin
				if (!out_v_q || take) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (put) begin
			if (!out_v_q || take) begin
				out_q <= in_res;
			end else begin
				skid_q <= in_res;
			end
		end
	end

`ifndef SYNTH
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid item held without a head item");
	a_skid_drains_first: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && take |=> out_v_q && !skid_v_q)
		else $error("skid item not moved to the head");
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ready |=> out_v_q && $stable(out_q))
		else $error("waiting result changed");
`endif

endmodule
